@@ hdl/i2c_eba_pkg.sv @@
// Shared types and constants for the I2C EEPROM byte access master.
// Step codes of the pin sequencer, micro step codes, and the sequencer state record.
// No dependencies.
`default_nettype none

package i2c_eba_pkg;

   localparam int unsigned DEV_ADDR_W = 7;
   localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'd80;

   // sequence step codes
   localparam logic [5:0] STEP_IDLE     = 6'd0;
   localparam logic [5:0] STEP_START    = 6'd1;
   localparam logic [5:0] STEP_START_END = 6'd4;
   localparam logic [5:0] STEP_DEV_WR   = 6'd5;
   localparam logic [5:0] STEP_WORD     = 6'd11;
   localparam logic [5:0] STEP_DATA     = 6'd17;
   localparam logic [5:0] STEP_RESTART  = 6'd23;
   localparam logic [5:0] STEP_RESTART_END = 6'd26;
   localparam logic [5:0] STEP_DEV_RD   = 6'd27;
   localparam logic [5:0] STEP_BYTE_END = 6'd32;
   localparam logic [5:0] STEP_READ     = 6'd33;
   localparam logic [5:0] STEP_READ_HI  = 6'd34;
   localparam logic [5:0] STEP_READ_LO  = 6'd35;
   localparam logic [5:0] STEP_NACK     = 6'd36;
   localparam logic [5:0] STEP_NACK_HI  = 6'd37;
   localparam logic [5:0] STEP_NACK_LO  = 6'd38;
   localparam logic [5:0] STEP_STOP     = 6'd39;
   localparam logic [5:0] STEP_STOP_HI  = 6'd40;
   localparam logic [5:0] STEP_STOP_END = 6'd41;

   // micro steps inside a start condition
   localparam logic [2:0] START_SDA_HI = 3'd0;
   localparam logic [2:0] START_SCL_HI = 3'd1;
   localparam logic [2:0] START_SDA_LO = 3'd2;
   localparam logic [2:0] START_SCL_LO = 3'd3;

   // micro steps inside a byte plus acknowledge
   localparam logic [2:0] BYTE_SDA    = 3'd0;
   localparam logic [2:0] BYTE_SCL_HI = 3'd1;
   localparam logic [2:0] BYTE_SCL_LO = 3'd2;
   localparam logic [2:0] ACK_SDA     = 3'd3;
   localparam logic [2:0] ACK_SCL_HI  = 3'd4;
   localparam logic [2:0] ACK_SCL_LO  = 3'd5;

   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef struct packed {
      logic [5:0] step;
      logic [2:0] bit_pos;
      logic [7:0] shift;
      logic       is_read;
      logic [7:0] held_addr;
      logic [7:0] held_data;
      logic [7:0] rcv_byte;
      logic       scl;
      logic       sda;
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_status_type;

endpackage

`default_nettype wire

@@ hdl/i2c_eba_if.sv @@
// Handshake channel interfaces of the I2C EEPROM byte access master:
// request, response and register write channels.
// Depends on i2c_eba_pkg.
`default_nettype none

interface i2c_eba_req_if;
   logic       valid;
   logic       ready;
   logic       begin_req;
   logic       command;
   logic [7:0] word_address;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, begin_req, command, word_address, write_data, sda_in,
                   input ready);
   modport sink   (input valid, begin_req, command, word_address, write_data, sda_in,
                   output ready);
endinterface

interface i2c_eba_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                   input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                   output ready);
endinterface

interface i2c_eba_csr_if;
   logic                              valid;
   logic                              ready;
   logic [i2c_eba_pkg::DEV_ADDR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ hdl/i2c_eba_step.sv @@
// Next-state logic of the I2C pin sequencer: one pin change per word.
// Depends on i2c_eba_pkg.
`default_nettype none

module i2c_eba_step (
   input  var i2c_eba_pkg::seq_state_type  cur_state,
   input  var logic                        begin_req,
   input  var logic                        command,
   input  var logic [7:0]                  word_address,
   input  var logic [7:0]                  write_data,
   input  var logic                        sda_in,
   input  var logic [i2c_eba_pkg::DEV_ADDR_W-1:0] dev_addr,
   output i2c_eba_pkg::seq_state_type      next_state,
   output i2c_eba_pkg::seq_status_type     status
);

   i2c_eba_pkg::seq_state_type s;
   i2c_eba_pkg::seq_state_type n;
   logic [7:0] dev_byte;
   logic [5:0] base;
   logic [2:0] micro;
   logic [5:0] start_next;
   logic [7:0] start_load;

   assign dev_byte = {dev_addr, 1'b0};

   always_comb begin
      s = cur_state;
      if (cur_state.step == i2c_eba_pkg::STEP_IDLE && begin_req) begin
         s.is_read   = command;
         s.held_addr = word_address;
         s.held_data = write_data;
         s.step      = i2c_eba_pkg::STEP_START;
      end

      n           = s;
      status.busy = 1'b0;
      status.done = 1'b0;
      base        = i2c_eba_pkg::STEP_DEV_WR;
      micro       = 3'd0;
      start_next  = i2c_eba_pkg::STEP_DEV_WR;
      start_load  = dev_byte;

      if (s.step != i2c_eba_pkg::STEP_IDLE) begin
         status.busy = (s.step <= i2c_eba_pkg::STEP_STOP_END);

         priority if (s.step <= i2c_eba_pkg::STEP_START_END ||
                      (s.step >= i2c_eba_pkg::STEP_RESTART &&
                       s.step <= i2c_eba_pkg::STEP_RESTART_END)) begin
            if (s.step <= i2c_eba_pkg::STEP_START_END) begin
               micro      = 3'(s.step - i2c_eba_pkg::STEP_START);
               start_next = i2c_eba_pkg::STEP_DEV_WR;
               start_load = dev_byte;
            end else begin
               micro      = 3'(s.step - i2c_eba_pkg::STEP_RESTART);
               start_next = i2c_eba_pkg::STEP_DEV_RD;
               start_load = dev_byte | 8'h01;
            end
            unique case (micro)
               i2c_eba_pkg::START_SDA_HI: begin
                  n.sda  = 1'b1;
                  n.step = s.step + 6'd1;
               end
               i2c_eba_pkg::START_SCL_HI: begin
                  n.scl  = 1'b1;
                  n.step = s.step + 6'd1;
               end
               i2c_eba_pkg::START_SDA_LO: begin
                  n.sda  = 1'b0;
                  n.step = s.step + 6'd1;
               end
               default: begin
                  n.scl     = 1'b0;
                  n.shift   = start_load;
                  n.bit_pos = 3'd0;
                  n.step    = start_next;
               end
            endcase
         end else if (s.step <= i2c_eba_pkg::STEP_BYTE_END) begin
            priority if (s.step < i2c_eba_pkg::STEP_WORD)     base = i2c_eba_pkg::STEP_DEV_WR;
            else if (s.step < i2c_eba_pkg::STEP_DATA)         base = i2c_eba_pkg::STEP_WORD;
            else if (s.step < i2c_eba_pkg::STEP_RESTART)      base = i2c_eba_pkg::STEP_DATA;
            else                                              base = i2c_eba_pkg::STEP_DEV_RD;
            micro = 3'(s.step - base);
            unique case (micro)
               i2c_eba_pkg::BYTE_SDA: begin
                  n.sda  = s.shift[7];
                  n.step = s.step + 6'd1;
               end
               i2c_eba_pkg::BYTE_SCL_HI: begin
                  n.scl  = 1'b1;
                  n.step = s.step + 6'd1;
               end
               i2c_eba_pkg::BYTE_SCL_LO: begin
                  n.scl   = 1'b0;
                  n.shift = {s.shift[6:0], 1'b0};
                  if (s.bit_pos < i2c_eba_pkg::LAST_BIT) begin
                     n.bit_pos = s.bit_pos + 3'd1;
                     n.step    = base;
                  end else begin
                     n.bit_pos = 3'd0;
                     n.step    = base + 6'(i2c_eba_pkg::ACK_SDA);
                  end
               end
               i2c_eba_pkg::ACK_SDA: begin
                  n.sda  = 1'b1;
                  n.step = s.step + 6'd1;
               end
               i2c_eba_pkg::ACK_SCL_HI: begin
                  // slave acknowledge is not checked
                  n.scl  = 1'b1;
                  n.step = s.step + 6'd1;
               end
               default: begin
                  n.scl = 1'b0;
                  priority if (base == i2c_eba_pkg::STEP_DEV_WR) begin
                     n.shift = s.held_addr;
                     n.step  = i2c_eba_pkg::STEP_WORD;
                  end else if (base == i2c_eba_pkg::STEP_WORD) begin
                     if (s.is_read) begin
                        n.step = i2c_eba_pkg::STEP_RESTART;
                     end else begin
                        n.shift = s.held_data;
                        n.step  = i2c_eba_pkg::STEP_DATA;
                     end
                  end else if (base == i2c_eba_pkg::STEP_DATA) begin
                     n.step = i2c_eba_pkg::STEP_STOP;
                  end else begin
                     n.step = i2c_eba_pkg::STEP_READ;
                  end
               end
            endcase
         end else begin
            unique case (s.step)
               i2c_eba_pkg::STEP_READ: begin
                  n.sda     = 1'b1;
                  n.shift   = 8'd0;
                  n.bit_pos = 3'd0;
                  n.step    = i2c_eba_pkg::STEP_READ_HI;
               end
               i2c_eba_pkg::STEP_READ_HI: begin
                  n.scl   = 1'b1;
                  n.shift = {s.shift[6:0], sda_in};
                  n.step  = i2c_eba_pkg::STEP_READ_LO;
               end
               i2c_eba_pkg::STEP_READ_LO: begin
                  n.scl = 1'b0;
                  if (s.bit_pos < i2c_eba_pkg::LAST_BIT) begin
                     n.bit_pos = s.bit_pos + 3'd1;
                     n.step    = i2c_eba_pkg::STEP_READ_HI;
                  end else begin
                     n.bit_pos  = 3'd0;
                     n.rcv_byte = s.shift;
                     n.step     = i2c_eba_pkg::STEP_NACK;
                  end
               end
               i2c_eba_pkg::STEP_NACK: begin
                  n.sda  = 1'b1;
                  n.step = i2c_eba_pkg::STEP_NACK_HI;
               end
               i2c_eba_pkg::STEP_NACK_HI: begin
                  n.scl  = 1'b1;
                  n.step = i2c_eba_pkg::STEP_NACK_LO;
               end
               i2c_eba_pkg::STEP_NACK_LO: begin
                  n.scl  = 1'b0;
                  n.step = i2c_eba_pkg::STEP_STOP;
               end
               i2c_eba_pkg::STEP_STOP: begin
                  n.sda  = 1'b0;
                  n.step = i2c_eba_pkg::STEP_STOP_HI;
               end
               i2c_eba_pkg::STEP_STOP_HI: begin
                  n.scl  = 1'b1;
                  n.step = i2c_eba_pkg::STEP_STOP_END;
               end
               i2c_eba_pkg::STEP_STOP_END: begin
                  n.sda       = 1'b1;
                  n.step      = i2c_eba_pkg::STEP_IDLE;
                  status.done = 1'b1;
               end
               default: begin
                  // stray step code: back to idle, lines untouched
                  n.step = i2c_eba_pkg::STEP_IDLE;
               end
            endcase
         end
      end
      next_state = n;
   end

endmodule

`default_nettype wire

@@ hdl/i2c_eeprom_byte_access_master.sv @@
// Top level of the I2C EEPROM byte access master.
// Holds sequencer state, the device address register and the response register.
// Depends on i2c_eba_pkg, i2c_eba_if and i2c_eba_step.
`default_nettype none

// Bit-banged I2C master for a single EEPROM byte write or random byte read.
// Every request word is one tick: it carries a start request (begin_req with
// command, word_address and write_data, taken only when the sequencer is idle)
// plus the sampled SDA level, and produces exactly one response word with the
// SCL/SDA levels after that tick's pin change, busy, done and the last read
// byte. A write takes 4 + 3*27 + 3 = 88 ticks (start, device address, word
// address, data, stop); a read takes 112 ticks (start, two address bytes,
// repeated start, address with read bit, eight read bits, NACK, stop).
// SDA drive is open drain style: 1 releases the line. Slave ACKs are clocked
// but never checked. Throughput is one word per clock while the response sink
// keeps up: the pin change is combinational from the sequencer state, and
// the state and response registers update on the same edge, so a response is
// offered in the cycle after its request is taken. The request side stays ready
// while a response is pending as long as the response sink takes it in that
// cycle. The device address register (reset 80) is written through the csr
// channel, which is always ready; write it only while the sequencer is idle.

module i2c_eeprom_byte_access_master (
   input  var logic         clock,
   input  var logic         reset,
   i2c_eba_req_if.sink      req_chan,
   i2c_eba_rsp_if.source    rsp_chan,
   i2c_eba_csr_if.sink      csr_chan
);

   i2c_eba_pkg::seq_state_type  state_ff;
   i2c_eba_pkg::seq_state_type  state_in;
   i2c_eba_pkg::seq_status_type status;

   logic [i2c_eba_pkg::DEV_ADDR_W-1:0] dev_addr_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_scl_ff;
   logic                               rsp_sda_ff;
   logic                               rsp_busy_ff;
   logic                               rsp_done_ff;
   logic [7:0]                         rsp_data_ff;
   logic                               req_take;

   // output register frees up in the same cycle it is drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   i2c_eba_step u_step (
      .cur_state    (state_ff),
      .begin_req    (req_chan.begin_req),
      .command      (req_chan.command),
      .word_address (req_chan.word_address),
      .write_data   (req_chan.write_data),
      .sda_in       (req_chan.sda_in),
      .dev_addr     (dev_addr_ff),
      .next_state   (state_in),
      .status       (status)
   );

   // sequencer state and device address
   always_ff @(posedge clock) begin
      if (reset) begin
         // both lines released
         state_ff    <= '{step: i2c_eba_pkg::STEP_IDLE, bit_pos: 3'd0, shift: 8'd0,
                          is_read: 1'b0, held_addr: 8'd0, held_data: 8'd0,
                          rcv_byte: 8'd0, scl: 1'b1, sda: 1'b1};
         dev_addr_ff <= i2c_eba_pkg::DEV_ADDR_RESET;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            dev_addr_ff <= csr_chan.data;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_scl_ff  <= state_in.scl;
         rsp_sda_ff  <= state_in.sda;
         rsp_busy_ff <= status.busy;
         rsp_done_ff <= status.done;
         rsp_data_ff <= state_in.rcv_byte;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.scl_out   = rsp_scl_ff;
   assign rsp_chan.sda_out   = rsp_sda_ff;
   assign rsp_chan.busy_res  = rsp_busy_ff;
   assign rsp_chan.done_res  = rsp_done_ff;
   assign rsp_chan.read_data = rsp_data_ff;

endmodule

`default_nettype wire
